/* sv/tfe_pkg.sv */
// Package for the timed fade envelope: field widths, phase codes and the
// microcode table that sequences the datapath. No dependencies.
package tfe_pkg;

	localparam int TIME_BITS    = 32;
	localparam int PHASE_BITS   = 3;
	localparam int LEVEL_BITS   = 17;
	localparam int FRAC_BITS    = 16;
	localparam int CNT_BITS     = $clog2(FRAC_BITS);
	localparam int NUM_TIMED    = 5;
	localparam int CFG_IDX_BITS = 3;
	localparam int STEP_BITS    = 3;

	typedef logic [TIME_BITS-1:0]    time_t;
	typedef logic [PHASE_BITS-1:0]   phase_t;
	typedef logic [LEVEL_BITS-1:0]   level_t;
	typedef logic [FRAC_BITS-1:0]    frac_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [STEP_BITS-1:0]    step_t;
	typedef logic [2:0]              op_t;
	typedef logic [2:0]              jc_t;

	localparam phase_t PHASE_START_WAIT = 3'd0;
	localparam phase_t PHASE_FADE_OUT   = 3'd3;
	localparam phase_t PHASE_DONE       = 3'd5;

	localparam level_t LEVEL_ONE  = level_t'(1) << FRAC_BITS;
	localparam level_t LEVEL_ZERO = '0;

	localparam cfg_idx_t REG_START_WAIT = 3'd0;
	localparam cfg_idx_t REG_FADE_IN    = 3'd1;
	localparam cfg_idx_t REG_HOLD       = 3'd2;
	localparam cfg_idx_t REG_FADE_OUT   = 3'd3;
	localparam cfg_idx_t REG_END_WAIT   = 3'd4;

	localparam op_t OP_NONE  = 3'd0;
	localparam op_t OP_FETCH = 3'd1;
	localparam op_t OP_CHECK = 3'd2;
	localparam op_t OP_SETUP = 3'd3;
	localparam op_t OP_DIV   = 3'd4;
	localparam op_t OP_FIN   = 3'd5;

	localparam jc_t JC_ALWAYS    = 3'd0;
	localparam jc_t JC_ACC_TICK  = 3'd1;
	localparam jc_t JC_NOLEVEL   = 3'd2;
	localparam jc_t JC_DIV_LAST  = 3'd3;
	localparam jc_t JC_OUT_TAKEN = 3'd4;

	localparam step_t STEP_FETCH = 3'd0;
	localparam step_t STEP_CHECK = 3'd1;
	localparam step_t STEP_SETUP = 3'd2;
	localparam step_t STEP_DIV   = 3'd3;
	localparam step_t STEP_FIN   = 3'd4;
	localparam step_t STEP_OUT   = 3'd5;

	typedef struct packed {
		logic  in_rdy;
		logic  out_vld;
		op_t   op;
		jc_t   jc;
		logic  hold;
		step_t tgt;
	} ctl_word_t;

	function automatic ctl_word_t ucode(input step_t step);
		ctl_word_t cw;
		cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_NONE, jc: JC_ALWAYS,
			hold: 1'b0, tgt: STEP_FETCH};
		unique case (step)
			STEP_FETCH: cw = '{in_rdy: 1'b1, out_vld: 1'b0, op: OP_FETCH,
				jc: JC_ACC_TICK, hold: 1'b1, tgt: STEP_CHECK};
			STEP_CHECK: cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_CHECK,
				jc: JC_ALWAYS, hold: 1'b0, tgt: STEP_SETUP};
			STEP_SETUP: cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_SETUP,
				jc: JC_NOLEVEL, hold: 1'b0, tgt: STEP_OUT};
			STEP_DIV:   cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_DIV,
				jc: JC_DIV_LAST, hold: 1'b1, tgt: STEP_FIN};
			STEP_FIN:   cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_FIN,
				jc: JC_ALWAYS, hold: 1'b0, tgt: STEP_OUT};
			STEP_OUT:   cw = '{in_rdy: 1'b0, out_vld: 1'b1, op: OP_NONE,
				jc: JC_OUT_TAKEN, hold: 1'b1, tgt: STEP_FETCH};
			default:    cw = '{in_rdy: 1'b0, out_vld: 1'b0, op: OP_NONE,
				jc: JC_ALWAYS, hold: 1'b0, tgt: STEP_FETCH};
		endcase
		return cw;
	endfunction

endpackage

/* sv/tfe_cfg_if.sv */
// Configuration write channel of the timed fade envelope.
// Depends on tfe_pkg for the index and data widths.
interface tfe_cfg_if import tfe_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	time_t    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/tfe_in_if.sv */
// Input item channel of the timed fade envelope: mode and current time.
// Depends on tfe_pkg for the field widths.
interface tfe_in_if import tfe_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  mode;
	time_t now_time;

	modport source(output valid, mode, now_time, input ready);
	modport sink(input valid, mode, now_time, output ready);
endinterface

/* sv/tfe_out_if.sv */
// Result channel of the timed fade envelope: phase and Q1.16 level.
// Depends on tfe_pkg for the field widths.
interface tfe_out_if import tfe_pkg::*; ();
	logic   valid;
	logic   ready;
	phase_t phase;
	level_t level;

	modport source(output valid, phase, level, input ready);
	modport sink(input valid, phase, level, output ready);
endinterface

/* sv/timed_fade_envelope_top.sv */
// Timed fade envelope top level: microcode sequencer, phase registers and a
// bit-serial divider. Depends on tfe_pkg and the three channel interfaces.
//
// A start transaction produces no result. A tick whose
// level is fixed (done phase or zero duration) shows its result after the
// check and setup steps; any other tick shows it after the check, setup,
// divide and finish steps, the restoring division forming one of the sixteen
// fraction bits per cycle. The next item is accepted in the cycle after the
// result transaction. Configuration writes are always ready and take effect
// in the next cycle.
module timed_fade_envelope_top import tfe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	tfe_cfg_if.sink  cfg,
	tfe_in_if.sink   item,
	tfe_out_if.source result
);

	time_t     dur_q [NUM_TIMED];
	phase_t    phase_q;
	time_t     origin_q;
	time_t     now_q;
	time_t     elapsed_q;
	time_t     rem_q;
	time_t     div_q;
	frac_t     quo_q;
	cnt_t      cnt_q;
	level_t    level_q;
	step_t     pc_q;

	ctl_word_t cw;
	time_t     cur_dur;
	logic      in_acc;
	logic      cond;
	logic [TIME_BITS:0] rem_sh;
	logic      quo_bit;

	assign cw     = ucode(pc_q);
	assign in_acc = item.valid && cw.in_rdy;
	assign cur_dur = (phase_q < PHASE_DONE) ? dur_q[phase_q[$clog2(NUM_TIMED)-1:0]] : '0;
	assign rem_sh  = {rem_q, 1'b0};
	assign quo_bit = rem_sh >= {1'b0, div_q};

	assign cfg.ready    = 1'b1;
	assign item.ready   = cw.in_rdy;
	assign result.valid = cw.out_vld;
	assign result.phase = phase_q;
	assign result.level = level_q;

	always_comb begin
		unique case (cw.jc)
			JC_ALWAYS:    cond = 1'b1;
			JC_ACC_TICK:  cond = in_acc && !item.mode;
			JC_NOLEVEL:   cond = (phase_q == PHASE_DONE) || (cur_dur == '0);
			JC_DIV_LAST:  cond = cnt_q == cnt_t'(FRAC_BITS - 1);
			JC_OUT_TAKEN: cond = result.ready;
			default:      cond = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (cond) begin
			pc_q <= cw.tgt;
		end else if (!cw.hold) begin
			pc_q <= pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMED; i++) begin
				dur_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_WAIT: dur_q[0] <= cfg.data;
				REG_FADE_IN:    dur_q[1] <= cfg.data;
				REG_HOLD:       dur_q[2] <= cfg.data;
				REG_FADE_OUT:   dur_q[3] <= cfg.data;
				REG_END_WAIT:   dur_q[4] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_START_WAIT;
			origin_q <= '0;
		end else begin
			unique case (cw.op)
				OP_FETCH: begin
					if (in_acc && item.mode) begin
						origin_q <= item.now_time;
					end
				end
				OP_CHECK: begin
					if (phase_q != PHASE_DONE && elapsed_q >= cur_dur) begin
						phase_q  <= phase_q + phase_t'(1);
						origin_q <= now_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_FETCH: begin
				if (in_acc) begin
					now_q     <= item.now_time;
					elapsed_q <= item.now_time - origin_q;
				end
			end
			OP_CHECK: begin
				if (phase_q != PHASE_DONE && elapsed_q >= cur_dur) begin
					elapsed_q <= '0;
				end
			end
			OP_SETUP: begin
				rem_q   <= elapsed_q;
				div_q   <= cur_dur;
				quo_q   <= '0;
				cnt_q   <= '0;
				level_q <= LEVEL_ZERO;
			end
			OP_DIV: begin
				rem_q <= quo_bit ? time_t'(rem_sh - {1'b0, div_q}) : time_t'(rem_sh);
				quo_q <= {quo_q[FRAC_BITS-2:0], quo_bit};
				cnt_q <= cnt_q + cnt_t'(1);
			end
			OP_FIN: begin
				level_q <= (phase_q == PHASE_FADE_OUT) ?
					LEVEL_ONE - {1'b0, quo_q} : {1'b0, quo_q};
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_DONE)
		else $error("phase register beyond done");

	a_done_level: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.phase == PHASE_DONE |-> result.level == LEVEL_ZERO)
		else $error("nonzero level in done phase");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.level <= LEVEL_ONE)
		else $error("level above one");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && !item.mode |=> !item.ready && !result.valid)
		else $error("sequencer did not leave fetch after a tick");

	a_out_return: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready |=> item.ready && !result.valid)
		else $error("sequencer did not return to fetch after a result");
`endif

endmodule
